[sv/mtt_pkg.sv]
package mtt_pkg;

    localparam int LEAVES  = 16;
    localparam int NODES   = 2 * LEAVES - 1;
    localparam int ADDR_W  = $clog2(NODES);
    localparam int CNT_W   = $clog2(LEAVES + 1);
    localparam int DATA_W  = 32;
    localparam int LIMIT_W = 5;
    localparam int USED_W  = 5;

    localparam logic signed [DATA_W-1:0] SENTINEL = -32'sd1;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_LOAD   = 2'd1,
        OP_INSERT = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_CLIMB_RD,
        ST_CLIMB_CMP,
        ST_REB_RD,
        ST_REB_WR,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic capture;
        logic clear;
        logic write_leaf;
        logic set_refused;
        logic reb_start;
        logic climb_write;
        logic reb_write;
        logic sel_reb;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        op_t  op;
        logic last;
        logic full;
        logic climb_win;
        logic parent_is_root;
        logic reb_done;
        logic out_free;
    } dp_status_t;

endpackage

[sv/mtt_node_ram.sv]
module mtt_node_ram (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   clear_all,
    input  logic                                   we,
    input  logic [mtt_pkg::ADDR_W-1:0]             waddr,
    input  logic signed [mtt_pkg::DATA_W-1:0]      wdata,
    input  logic [mtt_pkg::ADDR_W-1:0]             raddr_a,
    input  logic [mtt_pkg::ADDR_W-1:0]             raddr_b,
    output logic signed [mtt_pkg::DATA_W-1:0]      rdata_a,
    output logic signed [mtt_pkg::DATA_W-1:0]      rdata_b
);

    logic signed [mtt_pkg::DATA_W-1:0] mem [mtt_pkg::NODES];
    logic [mtt_pkg::NODES-1:0]         valid_reg;
    logic signed [mtt_pkg::DATA_W-1:0] rdata_a_reg;
    logic signed [mtt_pkg::DATA_W-1:0] rdata_b_reg;

    // entries never written since reset or clear read as the sentinel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (clear_all)
        begin
            valid_reg <= '0;
        end
        else if (we)
        begin
            valid_reg[waddr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a_reg <= valid_reg[raddr_a] ? mem[raddr_a] : mtt_pkg::SENTINEL;
        rdata_b_reg <= valid_reg[raddr_b] ? mem[raddr_b] : mtt_pkg::SENTINEL;
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

[sv/mtt_datapath.sv]
module mtt_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mtt_pkg::dp_cmd_t              cmd,
    output mtt_pkg::dp_status_t           status,
    input  logic [1:0]                    in_op,
    input  logic [31:0]                   in_value,
    input  logic                          in_last,
    input  logic                          cfg_wr,
    input  logic [mtt_pkg::LIMIT_W-1:0]   cfg_value,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [31:0]                   out_winner,
    output logic [mtt_pkg::USED_W-1:0]    out_used,
    output logic                          out_full
);

    mtt_pkg::op_t                        op_reg;
    logic signed [mtt_pkg::DATA_W-1:0]   value_reg;
    logic                                last_reg;
    logic [mtt_pkg::CNT_W-1:0]           count_reg;
    logic [mtt_pkg::LIMIT_W-1:0]         limit_reg;
    logic                                refused_reg;
    logic [mtt_pkg::ADDR_W-1:0]          idx_reg;
    logic [mtt_pkg::ADDR_W-1:0]          n_reg;
    logic signed [mtt_pkg::DATA_W-1:0]   root_reg;
    logic                                out_valid_reg;
    logic [31:0]                         out_winner_reg;
    logic [mtt_pkg::USED_W-1:0]          out_used_reg;
    logic                                out_full_reg;

    logic [mtt_pkg::CNT_W-1:0]           limit_force;
    logic [mtt_pkg::ADDR_W-1:0]          leaf_addr;
    logic [mtt_pkg::ADDR_W-1:0]          parent_addr;
    logic [mtt_pkg::ADDR_W-1:0]          left_addr;
    logic [mtt_pkg::ADDR_W-1:0]          right_addr;
    logic [mtt_pkg::ADDR_W-1:0]          raddr_a;
    logic signed [mtt_pkg::DATA_W-1:0]   rdata_a;
    logic signed [mtt_pkg::DATA_W-1:0]   rdata_b;
    logic                                we;
    logic [mtt_pkg::ADDR_W-1:0]          waddr;
    logic signed [mtt_pkg::DATA_W-1:0]   wdata;
    logic                                out_valid_next;

    assign limit_force = (int'(limit_reg) > mtt_pkg::LEAVES)
                       ? mtt_pkg::CNT_W'(mtt_pkg::LEAVES)
                       : mtt_pkg::CNT_W'(limit_reg);

    assign leaf_addr   = mtt_pkg::ADDR_W'(mtt_pkg::LEAVES - 1)
                       + mtt_pkg::ADDR_W'(count_reg);
    assign parent_addr = mtt_pkg::ADDR_W'(idx_reg - 1'b1) >> 1;
    assign left_addr   = {n_reg[mtt_pkg::ADDR_W-2:0], 1'b1};
    assign right_addr  = mtt_pkg::ADDR_W'(left_addr + 1'b1);
    assign raddr_a     = cmd.sel_reb ? left_addr : parent_addr;

    always_comb
    begin
        we    = 1'b0;
        waddr = leaf_addr;
        wdata = value_reg;
        if (cmd.write_leaf)
        begin
            we    = 1'b1;
            waddr = leaf_addr;
            wdata = value_reg;
        end
        else if (cmd.climb_write)
        begin
            we    = 1'b1;
            waddr = parent_addr;
            wdata = value_reg;
        end
        else if (cmd.reb_write)
        begin
            we    = 1'b1;
            waddr = n_reg;
            wdata = (rdata_b > rdata_a) ? rdata_b : rdata_a;
        end
    end

    mtt_node_ram u_ram (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear_all (cmd.clear),
        .we        (we),
        .waddr     (waddr),
        .wdata     (wdata),
        .raddr_a   (raddr_a),
        .raddr_b   (right_addr),
        .rdata_a   (rdata_a),
        .rdata_b   (rdata_b)
    );

    // input beat capture, walk indices and result payload, no reset needed on these
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= mtt_pkg::op_t'(in_op);
            value_reg <= in_value;
            last_reg  <= in_last;
        end
        if (cmd.write_leaf)
        begin
            idx_reg <= leaf_addr;
        end
        else if (cmd.climb_write)
        begin
            idx_reg <= parent_addr;
        end
        if (cmd.reb_start)
        begin
            n_reg <= mtt_pkg::ADDR_W'(mtt_pkg::LEAVES - 2);
        end
        else if (cmd.reb_write)
        begin
            n_reg <= mtt_pkg::ADDR_W'(n_reg - 1'b1);
        end
        if (cmd.out_load)
        begin
            out_winner_reg <= root_reg;
            out_used_reg   <= mtt_pkg::USED_W'(count_reg);
            out_full_reg   <= refused_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            limit_reg   <= mtt_pkg::LIMIT_RESET;
            refused_reg <= 1'b0;
            root_reg    <= mtt_pkg::SENTINEL;
        end
        else
        begin
            if (cfg_wr)
            begin
                limit_reg <= cfg_value;
            end
            if (cmd.capture)
            begin
                refused_reg <= 1'b0;
            end
            else if (cmd.set_refused)
            begin
                refused_reg <= 1'b1;
            end
            if (cmd.clear)
            begin
                count_reg <= '0;
            end
            else if (cmd.write_leaf)
            begin
                count_reg <= mtt_pkg::CNT_W'(count_reg + 1'b1);
            end
            // root mirror of node zero
            if (cmd.clear)
            begin
                root_reg <= mtt_pkg::SENTINEL;
            end
            else if (we && (waddr == '0))
            begin
                root_reg <= wdata;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign status.op             = op_reg;
    assign status.last           = last_reg;
    assign status.full           = (count_reg >= limit_force);
    assign status.climb_win      = (value_reg > rdata_a);
    assign status.parent_is_root = (parent_addr == '0);
    assign status.reb_done       = (n_reg == '0);
    assign status.out_free       = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign out_winner = out_winner_reg;
    assign out_used   = out_used_reg;
    assign out_full   = out_full_reg;

endmodule

[sv/mtt_ctrl.sv]
module mtt_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  mtt_pkg::dp_status_t        status,
    output mtt_pkg::dp_cmd_t           cmd
);

    mtt_pkg::state_t state_reg;
    mtt_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mtt_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mtt_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = mtt_pkg::ST_EXEC;
                end
            end
            mtt_pkg::ST_EXEC:
            begin
                case (status.op)
                    mtt_pkg::OP_LOAD:
                    begin
                        state_next = status.last ? mtt_pkg::ST_REB_RD : mtt_pkg::ST_FINISH;
                    end
                    mtt_pkg::OP_INSERT:
                    begin
                        state_next = status.full ? mtt_pkg::ST_FINISH : mtt_pkg::ST_CLIMB_RD;
                    end
                    default:
                    begin
                        state_next = mtt_pkg::ST_FINISH;
                    end
                endcase
            end
            mtt_pkg::ST_CLIMB_RD:
            begin
                state_next = mtt_pkg::ST_CLIMB_CMP;
            end
            mtt_pkg::ST_CLIMB_CMP:
            begin
                if (status.climb_win && !status.parent_is_root)
                begin
                    state_next = mtt_pkg::ST_CLIMB_RD;
                end
                else
                begin
                    state_next = mtt_pkg::ST_FINISH;
                end
            end
            mtt_pkg::ST_REB_RD:
            begin
                state_next = mtt_pkg::ST_REB_WR;
            end
            mtt_pkg::ST_REB_WR:
            begin
                state_next = status.reb_done ? mtt_pkg::ST_FINISH : mtt_pkg::ST_REB_RD;
            end
            mtt_pkg::ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = mtt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mtt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            mtt_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            mtt_pkg::ST_EXEC:
            begin
                case (status.op)
                    mtt_pkg::OP_CLEAR:
                    begin
                        cmd.clear = 1'b1;
                    end
                    mtt_pkg::OP_LOAD:
                    begin
                        cmd.set_refused = status.full;
                        cmd.write_leaf  = !status.full;
                        cmd.reb_start   = status.last;
                    end
                    mtt_pkg::OP_INSERT:
                    begin
                        cmd.set_refused = status.full;
                        cmd.write_leaf  = !status.full;
                    end
                    default:
                    begin
                        cmd.clear = 1'b0;
                    end
                endcase
            end
            mtt_pkg::ST_CLIMB_CMP:
            begin
                cmd.climb_write = status.climb_win;
            end
            mtt_pkg::ST_REB_RD:
            begin
                cmd.sel_reb = 1'b1;
            end
            mtt_pkg::ST_REB_WR:
            begin
                cmd.reb_write = 1'b1;
            end
            mtt_pkg::ST_FINISH:
            begin
                cmd.out_load = status.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

[sv/max_tournament_tree.sv]
// each input beat passes accept, dispatch and result load; an insert adds a climb with a
// read and a compare state per parent compared, a load with last adds a rebuild walk with
// a read and a write state per internal node (node memory: two read ports, one write port)
// one item in flight; the next input beat is taken the cycle after the result is registered
// reset (rst_n low, asynchronous): all nodes read as -1 through cleared valid bits,
// leaf count 0, leaf_limit 16, no clearing pass
module max_tournament_tree (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [31:0] value
    input  logic [1:0]  s_tuser,    // [1:0] operation
    input  logic        s_tlast,    // last_of_load
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // [31:0] winner, [36:32] leaves_used, [39:37] zero
    output logic        m_tuser,    // [0] full_error
    // leaf_limit register write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data
);

    mtt_pkg::dp_cmd_t    cmd;
    mtt_pkg::dp_status_t status;

    logic [31:0]                  out_winner;
    logic [mtt_pkg::USED_W-1:0]   out_used;

    // register writes must happen only while idle (the user's duty, the block does not enforce it); always ready
    assign cfg_ready = 1'b1;

    // sequencer: accept, dispatch, climb or rebuild walk, then result load
    mtt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // node memory, leaf counter, limit register and result register
    mtt_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .in_op      (s_tuser),
        .in_value   (s_tdata),
        .in_last    (s_tlast),
        .cfg_wr     (cfg_valid & cfg_ready),
        .cfg_value  (cfg_data),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_winner (out_winner),
        .out_used   (out_used),
        .out_full   (m_tuser)
    );

    // pack result beat, winner in the low bits
    assign m_tdata = {3'b000, out_used, out_winner};

endmodule

[sv/mtt_checker.sv]
module mtt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tuser
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // leaf count never exceeds the number of leaves, and the pad bits stay zero
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[36:32] <= 5'd16) && (m_tdata[39:37] == 3'b000))
        else $error("leaves_used out of range");

    // one item in flight: an accepted beat blocks the input
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while busy");

    // a new result only appears from a busy cycle
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result without work");

endmodule

bind max_tournament_tree mtt_checker u_mtt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
